// File: hdl/acms_pkg.sv
// Package: types and codes shared by the accumulator ALU block.
`default_nettype none
package acms_pkg;

   localparam logic       KIND_EXEC = 1'b0;
   localparam logic       KIND_LOAD = 1'b1;

   localparam logic [7:0] OP_MOV_B_LO = 8'h40;
   localparam logic [7:0] OP_MOV_B_HI = 8'h47;
   localparam logic [7:0] OP_MOV_C_LO = 8'h48;
   localparam logic [7:0] OP_MOV_C_HI = 8'h4C;
   localparam logic [7:0] OP_ALU_LO   = 8'h80;
   localparam logic [7:0] OP_ALU_HI   = 8'h97;

   localparam logic [1:0] GRP_ADD = 2'd0;
   localparam logic [1:0] GRP_ADC = 2'd1;
   localparam logic [1:0] GRP_SUB = 2'd2;

   localparam logic [2:0] SRC_B = 3'd0;
   localparam logic [2:0] SRC_C = 3'd1;
   localparam logic [2:0] SRC_D = 3'd2;
   localparam logic [2:0] SRC_E = 3'd3;
   localparam logic [2:0] SRC_H = 3'd4;
   localparam logic [2:0] SRC_L = 3'd5;
   localparam logic [2:0] SRC_M = 3'd6;
   localparam logic [2:0] SRC_A = 3'd7;

   localparam logic [2:0] SEL_A = 3'd0;
   localparam logic [2:0] SEL_B = 3'd1;
   localparam logic [2:0] SEL_C = 3'd2;
   localparam logic [2:0] SEL_D = 3'd3;
   localparam logic [2:0] SEL_E = 3'd4;
   localparam logic [2:0] SEL_H = 3'd5;
   localparam logic [2:0] SEL_L = 3'd6;

   typedef struct packed {
      logic       kind;
      logic [7:0] opcode;
      logic [7:0] mem_data;
      logic [2:0] reg_select;
      logic [7:0] reg_value;
   } req_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] b;
      logic [7:0] c;
      logic [7:0] d;
      logic [7:0] e;
      logic [7:0] h;
      logic [7:0] l;
      logic       carry;
      logic       zero;
      logic       sign;
   } arch_state_type;

endpackage
`default_nettype wire

// File: hdl/acms_req_if.sv
// Interface: request channel carrying one opcode or register load item.
`default_nettype none
interface acms_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] opcode;
   logic [7:0] mem_data;
   logic [2:0] reg_select;
   logic [7:0] reg_value;

   modport source (output valid, kind, opcode, mem_data, reg_select, reg_value,
                   input ready);
   modport sink   (input valid, kind, opcode, mem_data, reg_select, reg_value,
                   output ready);
endinterface
`default_nettype wire

// File: hdl/acms_rsp_if.sv
// Interface: response channel carrying the register and flag snapshot.
`default_nettype none
interface acms_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  acc_out;
   logic [7:0]  b_out;
   logic [7:0]  c_out;
   logic [7:0]  d_out;
   logic [7:0]  e_out;
   logic [7:0]  h_out;
   logic [7:0]  l_out;
   logic        carry_out;
   logic        zero_out;
   logic        sign_out;
   logic [15:0] hl_address;

   modport source (output valid, acc_out, b_out, c_out, d_out, e_out, h_out, l_out,
                          carry_out, zero_out, sign_out, hl_address,
                   input ready);
   modport sink   (input valid, acc_out, b_out, c_out, d_out, e_out, h_out, l_out,
                         carry_out, zero_out, sign_out, hl_address,
                   output ready);
endinterface
`default_nettype wire

// File: hdl/acms_exec.sv
// Execute logic: next architectural state from current state and one item.
`default_nettype none
module acms_exec
   import acms_pkg::*;
(
   input  var arch_state_type cur,
   input  var req_type        item,
   output arch_state_type     nxt
);

   logic [7:0] src;
   logic [8:0] alu_res;
   logic       is_mov_b;
   logic       is_mov_c;
   logic       is_alu;

   always_comb begin
      unique case (item.opcode[2:0])
         SRC_B:   src = cur.b;
         SRC_C:   src = cur.c;
         SRC_D:   src = cur.d;
         SRC_E:   src = cur.e;
         SRC_H:   src = cur.h;
         SRC_L:   src = cur.l;
         SRC_M:   src = item.mem_data;
         SRC_A:   src = cur.acc;
         default: src = cur.acc;
      endcase
   end

   always_comb begin
      unique case (item.opcode[4:3])
         GRP_ADD: alu_res = {1'b0, cur.acc} + {1'b0, src};
         GRP_ADC: alu_res = {1'b0, cur.acc} + {1'b0, src} + {8'd0, cur.carry};
         GRP_SUB: alu_res = {1'b0, cur.acc} - {1'b0, src};
         default: alu_res = {1'b0, cur.acc} + {1'b0, src};
      endcase
   end

   assign is_mov_b = (item.opcode >= OP_MOV_B_LO) && (item.opcode <= OP_MOV_B_HI);
   assign is_mov_c = (item.opcode >= OP_MOV_C_LO) && (item.opcode <= OP_MOV_C_HI);
   assign is_alu   = (item.opcode >= OP_ALU_LO)   && (item.opcode <= OP_ALU_HI);

   always_comb begin
      nxt = cur;
      if (item.kind == KIND_LOAD) begin
         unique case (item.reg_select)
            SEL_A:   nxt.acc = item.reg_value;
            SEL_B:   nxt.b   = item.reg_value;
            SEL_C:   nxt.c   = item.reg_value;
            SEL_D:   nxt.d   = item.reg_value;
            SEL_E:   nxt.e   = item.reg_value;
            SEL_H:   nxt.h   = item.reg_value;
            SEL_L:   nxt.l   = item.reg_value;
            default: nxt     = cur;
         endcase
      end else if (is_mov_b) begin
         nxt.b = src;
      end else if (is_mov_c) begin
         nxt.c = src;
      end else if (is_alu) begin
         nxt.acc   = alu_res[7:0];
         nxt.carry = alu_res[8];
         nxt.zero  = (alu_res[7:0] == 8'd0);
         nxt.sign  = alu_res[7];
      end
   end

endmodule
`default_nettype wire

// File: hdl/acms_state.sv
// Architectural state: accumulator, six general registers and three flags.
`default_nettype none
module acms_state
   import acms_pkg::*;
(
   input  var logic           clock,
   input  var logic           reset,
   input  var logic           update,
   input  var arch_state_type state_in,
   output arch_state_type     state_out
);

   arch_state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

   assign state_out = state_ff;

endmodule
`default_nettype wire

// File: hdl/accumulator_cpu_alu_mov_subset.sv
// Top level: accumulator ALU with register file, MOV subset and flags.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid / ready      kind, opcode, mem_data, reg_select, reg_value
//   rsp_chan  out  valid / ready      registers A..L, carry/zero/sign, hl_address
//
// An accepted item lands in the input register; it executes against the register
// file once the output register is free or emptying, and the snapshot is written
// to the output register. Throughput is one item per cycle while the output does
// not stall (flag and register feedback closes in the single execute stage).
// Synchronous reset clears the registers, flags and both valid bits.
// A stalled output holds its item; the input register keeps accepting while
// the execute stage drains into a free or emptying output register.
`default_nettype none
module accumulator_cpu_alu_mov_subset
   import acms_pkg::*;
(
   input  var logic  clock,
   input  var logic  reset,
   acms_req_if.sink   req_chan,
   acms_rsp_if.source rsp_chan
);

   logic           in_valid_ff;
   req_type        in_item_ff;
   logic           out_valid_ff;
   arch_state_type out_item_ff;
   logic           exec_go;
   arch_state_type state_cur;
   arch_state_type state_in;
   req_type        req_item;

   assign req_item = '{kind:       req_chan.kind,
                       opcode:     req_chan.opcode,
                       mem_data:   req_chan.mem_data,
                       reg_select: req_chan.reg_select,
                       reg_value:  req_chan.reg_value};

   assign exec_go        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || exec_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_item_ff <= req_item;
      end
   end

   acms_exec u_exec (
      .cur  (state_cur),
      .item (in_item_ff),
      .nxt  (state_in)
   );

   acms_state u_state (
      .clock     (clock),
      .reset     (reset),
      .update    (exec_go),
      .state_in  (state_in),
      .state_out (state_cur)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (exec_go) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (exec_go) begin
         out_item_ff <= state_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.acc_out    = out_item_ff.acc;
   assign rsp_chan.b_out      = out_item_ff.b;
   assign rsp_chan.c_out      = out_item_ff.c;
   assign rsp_chan.d_out      = out_item_ff.d;
   assign rsp_chan.e_out      = out_item_ff.e;
   assign rsp_chan.h_out      = out_item_ff.h;
   assign rsp_chan.l_out      = out_item_ff.l;
   assign rsp_chan.carry_out  = out_item_ff.carry;
   assign rsp_chan.zero_out   = out_item_ff.zero;
   assign rsp_chan.sign_out   = out_item_ff.sign;
   assign rsp_chan.hl_address = {out_item_ff.h, out_item_ff.l};

   // pending response always mirrors the live register file
   a_out_tracks_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_item_ff == state_cur))
      else $error("response differs from register file");

   a_exec_fills_out: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> out_valid_ff)
      else $error("executed item not presented");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !exec_go |=> $stable(state_cur))
      else $error("state changed without an item");

   a_load_keeps_flags: assert property (@(posedge clock) disable iff (reset)
      (exec_go && (in_item_ff.kind == KIND_LOAD)) |=>
         ($stable(state_cur.carry) && $stable(state_cur.zero) && $stable(state_cur.sign)))
      else $error("register load altered flags");

endmodule
`default_nettype wire

// File: tb/acms_state_checker.sv
`timescale 1ns / 100ps
// Checker: predicts the register and flag snapshot for each item and compares it.
module acms_state_checker
   import acms_pkg::*;
(
   input  var logic clock,
   input  var logic reset,
   acms_req_if      req_mon,
   acms_rsp_if      rsp_mon,
   output int       mismatches,
   output int       outstanding
);

   logic [7:0]     acc_q;
   logic [7:0]     gp_q [6];
   logic           carry_q;
   logic           zero_q;
   logic           sign_q;
   arch_state_type snapshot_q [$];

   function automatic logic [7:0] operand(input logic [2:0] src, input logic [7:0] mem);
      case (src)
         SRC_M:   return mem;
         SRC_A:   return acc_q;
         default: return gp_q[src];
      endcase
   endfunction

   task automatic execute_item(input req_type item);
      logic [8:0]     sum;
      logic [7:0]     src;
      arch_state_type snap;
      src = operand(item.opcode[2:0], item.mem_data);
      if (item.kind == KIND_LOAD) begin
         if (item.reg_select == SEL_A) begin
            acc_q = item.reg_value;
         end else if (item.reg_select <= SEL_L) begin
            gp_q[item.reg_select - SEL_B] = item.reg_value;
         end
      end else if (item.opcode >= OP_MOV_B_LO && item.opcode <= OP_MOV_B_HI) begin
         gp_q[SRC_B] = src;
      end else if (item.opcode >= OP_MOV_C_LO && item.opcode <= OP_MOV_C_HI) begin
         gp_q[SRC_C] = src;
      end else if (item.opcode >= OP_ALU_LO && item.opcode <= OP_ALU_HI) begin
         case (item.opcode[4:3])
            GRP_ADD: sum = {1'b0, acc_q} + {1'b0, src};
            GRP_ADC: sum = {1'b0, acc_q} + {1'b0, src} + {8'd0, carry_q};
            default: sum = {1'b0, acc_q} - {1'b0, src};  // bit 8 is the borrow
         endcase
         acc_q   = sum[7:0];
         carry_q = sum[8];
         zero_q  = (sum[7:0] == 8'd0);
         sign_q  = sum[7];
      end
      snap = '{acc: acc_q, b: gp_q[0], c: gp_q[1], d: gp_q[2], e: gp_q[3],
               h: gp_q[4], l: gp_q[5], carry: carry_q, zero: zero_q, sign: sign_q};
      snapshot_q.push_back(snap);
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s mismatch: got %h, expected %h", name, got, want));
      end
   endtask

   task automatic check_snapshot();
      arch_state_type want;
      if (snapshot_q.size() == 0) begin
         report_mismatch("result item with nothing expected");
         return;
      end
      want = snapshot_q.pop_front();
      compare_field("acc_out",    {8'd0, rsp_mon.acc_out}, {8'd0, want.acc});
      compare_field("b_out",      {8'd0, rsp_mon.b_out},   {8'd0, want.b});
      compare_field("c_out",      {8'd0, rsp_mon.c_out},   {8'd0, want.c});
      compare_field("d_out",      {8'd0, rsp_mon.d_out},   {8'd0, want.d});
      compare_field("e_out",      {8'd0, rsp_mon.e_out},   {8'd0, want.e});
      compare_field("h_out",      {8'd0, rsp_mon.h_out},   {8'd0, want.h});
      compare_field("l_out",      {8'd0, rsp_mon.l_out},   {8'd0, want.l});
      compare_field("carry_out",  {15'd0, rsp_mon.carry_out}, {15'd0, want.carry});
      compare_field("zero_out",   {15'd0, rsp_mon.zero_out},  {15'd0, want.zero});
      compare_field("sign_out",   {15'd0, rsp_mon.sign_out},  {15'd0, want.sign});
      compare_field("hl_address", rsp_mon.hl_address, {want.h, want.l});
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         acc_q   = 8'd0;
         foreach (gp_q[i]) gp_q[i] = 8'd0;
         carry_q = 1'b0;
         zero_q  = 1'b0;
         sign_q  = 1'b0;
         snapshot_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_snapshot();
         end
         if (req_mon.valid && req_mon.ready) begin
            execute_item('{kind: req_mon.kind, opcode: req_mon.opcode,
                           mem_data: req_mon.mem_data, reg_select: req_mon.reg_select,
                           reg_value: req_mon.reg_value});
         end
      end
      outstanding = snapshot_q.size();
   end

endmodule

// File: tb/accumulator_cpu_alu_mov_subset_test.sv
`timescale 1ns / 100ps
// Testbench top: drives opcodes and register loads into the ALU block and gives the verdict.
module accumulator_cpu_alu_mov_subset_test;
   import acms_pkg::*;

   localparam logic [1:0] OPC_MOV_PREFIX = 2'b01;
   localparam logic [1:0] OPC_ALU_PREFIX = 2'b10;
   localparam logic [2:0] MOV_DST_B      = 3'd0;
   localparam logic [2:0] MOV_DST_C      = 3'd1;
   localparam logic [2:0] SEL_NONE       = 3'd7;
   localparam int         RANDOM_ITEMS   = 625;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;

   acms_req_if req_chan ();
   acms_rsp_if rsp_chan ();

   accumulator_cpu_alu_mov_subset dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   acms_state_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic req_type exec_item(input logic [7:0] op, input logic [7:0] mem);
      return '{kind: KIND_EXEC, opcode: op, mem_data: mem,
               reg_select: 3'($urandom_range(0, 7)), reg_value: 8'($urandom)};
   endfunction

   function automatic req_type load_item(input logic [2:0] sel, input logic [7:0] val);
      return '{kind: KIND_LOAD, opcode: 8'($urandom), mem_data: 8'($urandom),
               reg_select: sel, reg_value: val};
   endfunction

   function automatic logic [7:0] alu_op(input logic [1:0] grp, input logic [2:0] src);
      return {OPC_ALU_PREFIX, 1'b0, grp, src};
   endfunction

   function automatic logic [7:0] mov_op(input logic [2:0] dst, input logic [2:0] src);
      return {OPC_MOV_PREFIX, dst, src};
   endfunction

   function automatic req_type random_item();
      int         r;
      logic [7:0] op;
      logic [2:0] sel;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         sel = ($urandom_range(0, 15) == 0) ? SEL_NONE : 3'($urandom_range(0, 6));
         return load_item(sel, 8'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 45) op = 8'($urandom_range(OP_ALU_LO, OP_ALU_HI));
      else if (r < 75) op = 8'($urandom_range(OP_MOV_B_LO, OP_MOV_C_HI));
      else if (r < 80) op = 8'($urandom_range(OP_MOV_C_HI + 1, OP_MOV_C_HI + 3));
      else op = 8'($urandom_range(0, 255));
      return exec_item(op, 8'($urandom));
   endfunction

   task automatic send_item(input req_type item);
      req_chan.kind       = item.kind;
      req_chan.opcode     = item.opcode;
      req_chan.mem_data   = item.mem_data;
      req_chan.reg_select = item.reg_select;
      req_chan.reg_value  = item.reg_value;
      req_chan.valid      = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         req_chan.valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // result side: runs of ready, stalls mostly short, some long
   initial begin
      int left;
      left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (left > 0) begin
            left--;
         end else if ($urandom_range(0, 9) < 7) begin
            rsp_chan.ready = 1'b1;
            left = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 5);
         end else begin
            rsp_chan.ready = 1'b0;
            left = gap_cycles();
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.kind       = KIND_EXEC;
      req_chan.opcode     = 8'd0;
      req_chan.mem_data   = 8'd0;
      req_chan.reg_select = SEL_A;
      req_chan.reg_value  = 8'd0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      send_item(load_item(SEL_A, 8'hFF));
      send_item(load_item(SEL_B, 8'h01));
      send_item(load_item(SEL_C, 8'h80));
      send_item(load_item(SEL_D, 8'h7F));
      idle_for(gap_cycles());
      send_item(load_item(SEL_E, 8'h00));
      send_item(load_item(SEL_H, 8'hFF));
      send_item(load_item(SEL_L, 8'h00));
      send_item(load_item(SEL_NONE, 8'h55));
      // carry out with zero, carry in, borrow, and self operands
      send_item(exec_item(alu_op(GRP_ADD, SRC_B), 8'h00));
      send_item(exec_item(alu_op(GRP_ADC, SRC_C), 8'h00));
      send_item(exec_item(alu_op(GRP_SUB, SRC_D), 8'h00));
      idle_for(gap_cycles());
      send_item(exec_item(alu_op(GRP_SUB, SRC_M), 8'hFF));
      send_item(exec_item(alu_op(GRP_ADC, SRC_M), 8'hFF));
      send_item(exec_item(alu_op(GRP_ADD, SRC_A), 8'h00));
      send_item(exec_item(alu_op(GRP_SUB, SRC_A), 8'h00));
      send_item(exec_item(mov_op(MOV_DST_B, SRC_M), 8'hA5));
      send_item(exec_item(mov_op(MOV_DST_B, SRC_A), 8'h00));
      send_item(exec_item(mov_op(MOV_DST_C, SRC_H), 8'h00));
      send_item(exec_item(mov_op(MOV_DST_C, SRC_B), 8'h00));
      // opcodes outside the executed ranges
      send_item(exec_item(OP_MOV_C_HI + 8'd1, 8'hFF));
      send_item(exec_item(OP_MOV_C_HI + 8'd3, 8'hFF));
      send_item(exec_item(OP_ALU_HI + 8'd1, 8'hFF));
      send_item(exec_item(OP_MOV_B_LO - 8'd1, 8'hFF));
      send_item(exec_item(8'h00, 8'h00));
      send_item(exec_item(8'hFF, 8'hFF));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            req_chan.valid = 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
         send_item(random_item());
         if ((i / 64) % 4 != 1) idle_for(gap_cycles());
      end
      req_chan.valid = 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
